/* sv/ffba_pkg.sv */
// Package with shared types and codes of the first-fit block allocator.
package ffba_pkg;

    localparam int REQ_W    = 17;
    localparam int STATUS_W = 3;
    localparam int GRANT_W  = 16;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTSTART = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_A_CHK,
        S_A_EV,
        S_SH_CHK,
        S_SH_WR,
        S_INS,
        S_R_CHK,
        S_R_EV,
        S_MK_RD,
        S_MK_WR,
        S_M_RD0,
        S_M_LD0,
        S_M_CHK,
        S_M_EV,
        S_M_FIN,
        S_DONE
    } state_t;

endpackage

/* sv/ffba_mem.sv */
// Block table memory: one write port, one read port with registered data.
module ffba_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 18
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* sv/first_fit_block_allocator.sv */
// First-fit block allocator with split on allocate and coalesce on release.
//
// Input channel (in_valid / in_stall): req_type selects allocate (0) or
// release (1); request_bytes is the payload wanted, payload_offset the payload
// to release. Output channel (out_valid / out_stall): one item per request
// with status and granted_offset (zero unless an allocate succeeds).
// Requests are handled one at a time. The block table sits in one memory;
// the sequencer walks it in address order through the single read port.
// Allocate scans blocks in address order and, on a split, shifts the later
// blocks up one slot. Release scans blocks up to the target, then runs a
// merge pass over the whole table, joining adjacent free blocks.
// A new request is taken while the previous result still waits; the result
// of that request is held back until the output register is free, so a
// stalled receiver stops the block after at most one request in flight.
// After reset the block first writes the initial free block and
// then accepts requests; no other clearing is needed.
module first_fit_block_allocator #(
    parameter int ARENA_BYTES  = 65536,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [ffba_pkg::REQ_W-1:0]      request_bytes,
    input  logic [ffba_pkg::REQ_W-1:0]      payload_offset,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ffba_pkg::STATUS_W-1:0]   status,
    output logic [ffba_pkg::GRANT_W-1:0]    granted_offset
);

    import ffba_pkg::*;

    localparam int SIZE_W = $clog2(ARENA_BYTES + 1);
    localparam int WIDE_W = ((SIZE_W > REQ_W) ? SIZE_W : REQ_W) + 2;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int ENT_W  = SIZE_W + 1;

    localparam logic [WIDE_W-1:0] HDR_W   = WIDE_W'(HEADER_BYTES);
    localparam logic [WIDE_W-1:0] ARENA_W = WIDE_W'(ARENA_BYTES);
    localparam logic [SIZE_W-1:0] INIT_SZ = SIZE_W'(ARENA_BYTES - HEADER_BYTES);
    localparam logic [CNT_W-1:0]  MAX_C   = CNT_W'(MAX_BLOCKS);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic [IDX_W-1:0]    widx_reg, widx_next;
    logic [WIDE_W-1:0]   start_reg, start_next;
    logic                kind_reg, kind_next;
    logic [REQ_W-1:0]    want_reg, want_next;
    logic [REQ_W-1:0]    off_reg, off_next;
    logic [SIZE_W-1:0]   rem_reg, rem_next;
    logic [SIZE_W-1:0]   cur_size_reg, cur_size_next;
    logic                cur_free_reg, cur_free_next;
    logic [STATUS_W-1:0] st_reg, st_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [GRANT_W-1:0]  grant_reg, grant_next;

    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [ENT_W-1:0] rd_data, wr_data;
    logic             wr_en;

    logic              rd_free;
    logic [SIZE_W-1:0] rd_size;
    logic [WIDE_W-1:0] rd_size_w, want_w, start_hdr;
    logic [IDX_W-1:0]  idx;
    logic              in_acc, out_free;

    assign rd_free   = rd_data[ENT_W-1];
    assign rd_size   = rd_data[SIZE_W-1:0];
    assign rd_size_w = WIDE_W'(rd_size);
    assign want_w    = WIDE_W'(want_reg);
    assign start_hdr = start_reg + HDR_W;
    assign idx       = scan_reg[IDX_W-1:0];
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    ffba_mem #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (ENT_W)
    ) u_mem (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        widx_reg     <= widx_next;
        start_reg    <= start_next;
        kind_reg     <= kind_next;
        want_reg     <= want_next;
        off_reg      <= off_next;
        rem_reg      <= rem_next;
        cur_size_reg <= cur_size_next;
        cur_free_reg <= cur_free_next;
        st_reg       <= st_next;
        status_reg   <= status_next;
        grant_reg    <= grant_next;
    end

    // next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        widx_next      = widx_reg;
        start_next     = start_reg;
        kind_next      = kind_reg;
        want_next      = want_reg;
        off_next       = off_reg;
        rem_next       = rem_reg;
        cur_size_next  = cur_size_reg;
        cur_free_next  = cur_free_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        grant_next     = grant_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    kind_next  = req_type;
                    want_next  = request_bytes;
                    off_next   = payload_offset;
                    scan_next  = '0;
                    start_next = '0;
                    if (req_type == REQ_ALLOC)
                    begin
                        state_next = S_A_CHK;
                    end
                    else if (WIDE_W'(payload_offset) > ARENA_W)
                    begin
                        st_next    = ST_OUTSIDE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_R_CHK;
                    end
                end
            end
            S_A_CHK:
            begin
                if (scan_reg == cnt_reg)
                begin
                    st_next    = ST_NOFIT;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_A_EV;
                end
            end
            S_A_EV:
            begin
                if (rd_free && rd_size_w >= want_w)
                begin
                    if (rd_size_w == want_w)
                    begin
                        st_next    = ST_OK;
                        state_next = S_DONE;
                    end
                    else if (rd_size_w > want_w + HDR_W)
                    begin
                        if (cnt_reg == MAX_C)
                        begin
                            st_next    = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            rem_next   = SIZE_W'(rd_size_w - want_w - HDR_W);
                            widx_next  = IDX_W'(cnt_reg - CNT_W'(1));
                            state_next = S_SH_CHK;
                        end
                    end
                    else
                    begin
                        st_next    = ST_NOFIT;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    start_next = start_hdr + rd_size_w;
                    scan_next  = scan_reg + CNT_W'(1);
                    state_next = S_A_CHK;
                end
            end
            S_SH_CHK:
            begin
                if (widx_reg == idx)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                widx_next  = widx_reg - IDX_W'(1);
                state_next = S_SH_CHK;
            end
            S_INS:
            begin
                cnt_next   = cnt_reg + CNT_W'(1);
                st_next    = ST_OK;
                state_next = S_DONE;
            end
            S_R_CHK:
            begin
                if (scan_reg == cnt_reg)
                begin
                    st_next    = ST_NOTSTART;
                    state_next = S_DONE;
                end
                else if (start_hdr == WIDE_W'(off_reg))
                begin
                    state_next = S_MK_RD;
                end
                else
                begin
                    state_next = S_R_EV;
                end
            end
            S_R_EV:
            begin
                start_next = start_hdr + rd_size_w;
                scan_next  = scan_reg + CNT_W'(1);
                state_next = S_R_CHK;
            end
            S_MK_RD:
            begin
                state_next = S_MK_WR;
            end
            S_MK_WR:
            begin
                state_next = S_M_RD0;
            end
            S_M_RD0:
            begin
                state_next = S_M_LD0;
            end
            S_M_LD0:
            begin
                cur_size_next = rd_size;
                cur_free_next = rd_free;
                scan_next     = CNT_W'(1);
                widx_next     = '0;
                state_next    = S_M_CHK;
            end
            S_M_CHK:
            begin
                if (scan_reg == cnt_reg)
                begin
                    state_next = S_M_FIN;
                end
                else
                begin
                    state_next = S_M_EV;
                end
            end
            S_M_EV:
            begin
                if (cur_free_reg && rd_free)
                begin
                    cur_size_next = SIZE_W'(WIDE_W'(cur_size_reg) + rd_size_w + HDR_W);
                end
                else
                begin
                    widx_next     = widx_reg + IDX_W'(1);
                    cur_size_next = rd_size;
                    cur_free_next = rd_free;
                end
                scan_next  = scan_reg + CNT_W'(1);
                state_next = S_M_CHK;
            end
            S_M_FIN:
            begin
                cnt_next   = CNT_W'(widx_reg) + CNT_W'(1);
                st_next    = ST_OK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    if (st_reg == ST_OK && kind_reg == REQ_ALLOC)
                    begin
                        grant_next = start_hdr[GRANT_W-1:0];
                    end
                    else
                    begin
                        grant_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory port and handshake outputs
    always_comb
    begin
        in_stall = (state_reg != S_IDLE);
        rd_addr  = idx;
        wr_en    = 1'b0;
        wr_addr  = idx;
        wr_data  = rd_data;

        case (state_reg)
            S_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {1'b1, INIT_SZ};
            end
            S_A_EV:
            begin
                if (rd_free && rd_size_w >= want_w)
                begin
                    if (rd_size_w == want_w)
                    begin
                        wr_en   = 1'b1;
                        wr_data = {1'b0, rd_size};
                    end
                    else if (rd_size_w > want_w + HDR_W && cnt_reg != MAX_C)
                    begin
                        wr_en   = 1'b1;
                        wr_data = {1'b0, SIZE_W'(want_w)};
                    end
                end
            end
            S_SH_CHK:
            begin
                rd_addr = widx_reg;
            end
            S_SH_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = widx_reg + IDX_W'(1);
                wr_data = rd_data;
            end
            S_INS:
            begin
                wr_en   = 1'b1;
                wr_addr = idx + IDX_W'(1);
                wr_data = {1'b1, rem_reg};
            end
            S_MK_WR:
            begin
                wr_en   = 1'b1;
                wr_data = {1'b1, rd_size};
            end
            S_M_RD0:
            begin
                rd_addr = '0;
            end
            S_M_EV:
            begin
                if (!(cur_free_reg && rd_free))
                begin
                    wr_en   = 1'b1;
                    wr_addr = widx_reg;
                    wr_data = {cur_free_reg, cur_size_reg};
                end
            end
            S_M_FIN:
            begin
                wr_en   = 1'b1;
                wr_addr = widx_reg;
                wr_data = {cur_free_reg, cur_size_reg};
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign granted_offset = grant_reg;

endmodule
